### hdl/tournament_branch_predictor_defines.svh
// Assertion macros for the checker of the branch predictor.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TBP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tbp check failed");

// Next-cycle implication, disabled while reset is high.
`define TBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tbp check failed");

// Next-cycle implication that stays armed through reset.
`define TBP_ASSERT_NEXT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tbp check failed");

`endif

### hdl/tbp_pkg.sv
`default_nettype none
package tbp_pkg;

   localparam int TABLE_ENTRIES = 2048;
   localparam int HISTORY_BITS  = 11;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int EXT_BITS      = (IDX_BITS > HISTORY_BITS) ? IDX_BITS : HISTORY_BITS;

   localparam logic [1:0] CTR_STRONG_TAKEN = 2'd3;
   localparam logic [1:0] CTR_STRONG_NOT   = 2'd0;
   localparam logic [1:0] CHOOSE_BIMODAL   = 2'd2;

   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [HISTORY_BITS-1:0] hist_type;

   typedef struct packed {
      logic       g_guess;
      logic       b_guess;
      logic       c_guess;
      logic       c_ok;
      logic [1:0] gsh_next;
      logic [1:0] bim_next;
      logic [1:0] cho_next;
   } upd_type;

   // Saturating 2-bit counter step.
   function automatic logic [1:0] train2(input logic [1:0] ctr, input logic up);
      logic [1:0] res;
      if (up) begin
         res = (ctr == CTR_STRONG_TAKEN) ? ctr : ctr + 2'd1;
      end else begin
         res = (ctr == CTR_STRONG_NOT) ? ctr : ctr - 2'd1;
      end
      return res;
   endfunction

   // Address index XOR history, cut to the table size.
   function automatic idx_type gshare_index(input idx_type bi, input hist_type hist);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(hist);
      return bi ^ ext[IDX_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/tournament_branch_predictor.sv
`default_nettype none
// A taken request has its table entries read into registers; from ST_READ the tables are then
// updated and the result loaded, and a waiting result holds that load until rsp_ready.
// A new request is taken only once the previous one has written back its tables.
// A new request is taken while the previous result still waits on rsp_ready.
// Reset: synchronous; a clearing pass then fills all TABLE_ENTRIES (2048) entries of the tables,
// with req_ready low until it completes.
module tournament_branch_predictor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_branch_address,
   input  wire logic        req_taken,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_gshare_guess,
   output logic             rsp_bimodal_guess,
   output logic             rsp_chosen_guess,
   output logic             rsp_chosen_correct,
   output logic [31:0]      rsp_correct_total,
   output logic [31:0]      rsp_branch_total
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0] state_ff, state_in;
   tbp_pkg::idx_type  clr_ff, clr_in;
   tbp_pkg::hist_type hist_ff, hist_in;
   logic [31:0] correct_ff, correct_in;
   logic [31:0] branch_ff, branch_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // captured request, held while the tables are read
   tbp_pkg::idx_type bidx_ff, bidx_in;
   tbp_pkg::idx_type gidx_ff, gidx_in;
   logic             taken_ff, taken_in;

   logic g_guess_ff, b_guess_ff, c_guess_ff, c_ok_ff;

   // Tables: gshare alone; bimodal and chooser share the address index.
   logic [1:0] gsh_mem [tbp_pkg::TABLE_ENTRIES];
   logic [3:0] bc_mem  [tbp_pkg::TABLE_ENTRIES];
   logic [1:0] gsh_rd_ff;
   logic [3:0] bc_rd_ff;

   logic             accept;
   logic             commit;
   logic             out_free;
   logic             gsh_we, bc_we;
   tbp_pkg::idx_type gsh_waddr, bc_waddr;
   logic [1:0]       gsh_wdata;
   logic [3:0]       bc_wdata;
   tbp_pkg::idx_type req_bidx;
   tbp_pkg::upd_type upd;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_READ) && out_free;
   assign req_bidx  = req_branch_address[tbp_pkg::IDX_BITS-1:0];

   tbp_update u_update (
      .gsh_ctr (gsh_rd_ff),
      .bim_ctr (bc_rd_ff[3:2]),
      .cho_ctr (bc_rd_ff[1:0]),
      .taken   (taken_ff),
      .upd     (upd)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      hist_in      = hist_ff;
      correct_in   = correct_ff;
      branch_in    = branch_ff;
      rsp_valid_in = rsp_valid_ff;
      bidx_in      = bidx_ff;
      gidx_in      = gidx_ff;
      taken_in     = taken_ff;
      gsh_we       = 1'b0;
      bc_we        = 1'b0;
      gsh_waddr    = gidx_ff;
      bc_waddr     = bidx_ff;
      gsh_wdata    = upd.gsh_next;
      bc_wdata     = {upd.bim_next, upd.cho_next};

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            gsh_we    = 1'b1;
            bc_we     = 1'b1;
            gsh_waddr = clr_ff;
            bc_waddr  = clr_ff;
            gsh_wdata = tbp_pkg::CTR_STRONG_TAKEN;
            bc_wdata  = {tbp_pkg::CTR_STRONG_TAKEN, tbp_pkg::CTR_STRONG_NOT};
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               bidx_in  = req_bidx;
               gidx_in  = tbp_pkg::gshare_index(req_bidx, hist_ff);
               taken_in = req_taken;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // hold the read data until the output register has room
            if (commit) begin
               gsh_we       = 1'b1;
               bc_we        = 1'b1;
               hist_in      = {hist_ff[tbp_pkg::HISTORY_BITS-2:0], taken_ff};
               branch_in    = branch_ff + 32'd1;
               correct_in   = correct_ff + {31'd0, upd.c_ok};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hist_ff      <= '0;
         correct_ff   <= '0;
         branch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hist_ff      <= hist_in;
         correct_ff   <= correct_in;
         branch_ff    <= branch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bidx_ff  <= bidx_in;
      gidx_ff  <= gidx_in;
      taken_ff <= taken_in;
      if (commit) begin
         g_guess_ff <= upd.g_guess;
         b_guess_ff <= upd.b_guess;
         c_guess_ff <= upd.c_guess;
         c_ok_ff    <= upd.c_ok;
      end
   end

   // Table ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (gsh_we) begin
         gsh_mem[gsh_waddr] <= gsh_wdata;
      end
      if (accept) begin
         gsh_rd_ff <= gsh_mem[tbp_pkg::gshare_index(req_bidx, hist_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (bc_we) begin
         bc_mem[bc_waddr] <= bc_wdata;
      end
      if (accept) begin
         bc_rd_ff <= bc_mem[req_bidx];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gshare_guess   = g_guess_ff;
   assign rsp_bimodal_guess  = b_guess_ff;
   assign rsp_chosen_guess   = c_guess_ff;
   assign rsp_chosen_correct = c_ok_ff;
   // the running totals change only when a new result is loaded
   assign rsp_correct_total  = correct_ff;
   assign rsp_branch_total   = branch_ff;

endmodule
`default_nettype wire

### hdl/tbp_update.sv
`default_nettype none
// Form the predictions and the trained counter values for one branch.
module tbp_update (
   input  wire logic [1:0]      gsh_ctr,
   input  wire logic [1:0]      bim_ctr,
   input  wire logic [1:0]      cho_ctr,
   input  wire logic            taken,
   output tbp_pkg::upd_type     upd
);

   logic g_ok;
   logic b_ok;

   always_comb begin
      upd.g_guess  = gsh_ctr[1];
      upd.b_guess  = bim_ctr[1];
      upd.c_guess  = (cho_ctr >= tbp_pkg::CHOOSE_BIMODAL) ? bim_ctr[1] : gsh_ctr[1];
      upd.c_ok     = (upd.c_guess == taken);
      g_ok         = (gsh_ctr[1] == taken);
      b_ok         = (bim_ctr[1] == taken);
      upd.gsh_next = tbp_pkg::train2(gsh_ctr, taken);
      upd.bim_next = tbp_pkg::train2(bim_ctr, taken);
      // move the chooser toward whichever predictor alone was right
      if (g_ok && !b_ok) begin
         upd.cho_next = tbp_pkg::train2(cho_ctr, 1'b0);
      end else if (!g_ok && b_ok) begin
         upd.cho_next = tbp_pkg::train2(cho_ctr, 1'b1);
      end else begin
         upd.cho_next = cho_ctr;
      end
   end

endmodule
`default_nettype wire

### hdl/tbp_checker.sv
`default_nettype none
`include "tournament_branch_predictor_defines.svh"
module tbp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_gshare_guess,
   input wire logic        rsp_bimodal_guess,
   input wire logic        rsp_chosen_guess,
   input wire logic [31:0] rsp_branch_total
);

   // a stalled result holds
   `TBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_branch_total))
   // the chosen guess is one of the two predictions
   `TBP_ASSERT_IMPL(a_chosen_src, rsp_valid, (rsp_chosen_guess == rsp_gshare_guess) || (rsp_chosen_guess == rsp_bimodal_guess))
   // the clearing pass keeps requests out right after reset
   `TBP_ASSERT_NEXT_RST(a_reset_clear, reset, !req_ready && !rsp_valid)
   // one branch in flight at a time
   `TBP_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready)

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_gshare_guess  (rsp_gshare_guess),
   .rsp_bimodal_guess (rsp_bimodal_guess),
   .rsp_chosen_guess  (rsp_chosen_guess),
   .rsp_branch_total  (rsp_branch_total)
);
`default_nettype wire
